@@ design/cti_pkg.sv @@
// Shared types and constants for the calibration table interpolator.
// Used by the channel interfaces, the controller, the datapath and the top level.
// Depends on nothing.
package cti_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int MAX_ENTRIES = 255;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int KIND_W = 3;
  localparam int EIDX_W = 9;
  localparam int VQ_W   = 24;
  localparam int VAL_W  = 32;
  localparam int VOLT_W = 16;
  localparam int STAT_W = 2;

  // interpolation arithmetic widths
  localparam int MA_W   = VAL_W;
  localparam int MB_W   = VQ_W;
  localparam int PROD_W = MA_W + MB_W;
  localparam int DEN_W  = VOLT_W + 8;
  localparam int DIV_W  = PROD_W + 1;
  localparam int DCNT_W = $clog2(DIV_W);
  localparam int SUM_W  = DIV_W + 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE  = 3'd0,
    KIND_APPEND = 3'd1,
    KIND_SORT   = 3'd2,
    KIND_LOOKUP = 3'd3,
    KIND_INTERP = 3'd4
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    OP_NOP, OP_LATCH, OP_WR_IDX, OP_ERR_IDX, OP_APPEND, OP_ERR_FULL,
    OP_SK_INIT, OP_SK_READ, OP_SK_KEY, OP_SK_SHIFT, OP_SK_PUT,
    OP_READ0, OP_DD_FIRST, OP_DD_STEP, OP_DD_END,
    OP_LK_START, OP_LK_STEP, OP_LK_HIT,
    OP_IN_FIRST, OP_IN_ONE, OP_IN_STEP, OP_IN_SEG, OP_IN_FLAT, OP_IN_SETUP,
    OP_MUL, OP_DIV_INIT, OP_DIV, OP_FIN
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              idx_oor;
    logic              full;
    logic              cnt_zero;
    logic              cnt_one;
    logic              cnt_lt2;
    logic              i_last;
    logic              j_one;
    logic              sk_gt;
    logic              lk_hit;
    logic              in_stop;
    logic              in_flat;
    logic              mul_done;
    logic              div_done;
  } stat_t;

endpackage

@@ design/cti_if.sv @@
// Request and result channel interfaces with valid/ready handshake.
// Depends on cti_pkg for the field widths.
interface cti_req_if import cti_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [EIDX_W-1:0] entry_index;
  logic [VQ_W-1:0]   voltage_q8;
  logic [VAL_W-1:0]  entry_value;

  modport source (output valid, kind, entry_index, voltage_q8, entry_value, input ready);
  modport sink   (input valid, kind, entry_index, voltage_q8, entry_value, output ready);
endinterface

interface cti_rsp_if import cti_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VAL_W-1:0]  result_value;
  logic              found;
  logic [STAT_W-1:0] status;
  logic [CNT_W-1:0]  entry_count;

  modport source (output valid, result_value, found, status, entry_count, input ready);
  modport sink   (input valid, result_value, found, status, entry_count, output ready);
endinterface

@@ design/cti_ctrl.sv @@
// Controller state machine: sequences each request through the datapath.
// Depends on cti_pkg for the command and status structs.
module cti_ctrl import cti_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  req_valid_i,
  output logic  req_ready_o,
  output logic  rsp_valid_o,
  input  logic  rsp_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [17:0] {
    S_IDLE     = 18'h00001,
    S_EXEC     = 18'h00002,
    S_SK_RD    = 18'h00004,
    S_SK_KEY   = 18'h00008,
    S_SK_CMP   = 18'h00010,
    S_SK_PUT   = 18'h00020,
    S_DD_RD0   = 18'h00040,
    S_DD_FIRST = 18'h00080,
    S_DD_CMP   = 18'h00100,
    S_DD_END   = 18'h00200,
    S_LK_CMP   = 18'h00400,
    S_IN_FIRST = 18'h00800,
    S_IN_SCAN  = 18'h01000,
    S_IN_CHK   = 18'h02000,
    S_MUL      = 18'h04000,
    S_DIV      = 18'h08000,
    S_FIN      = 18'h10000,
    S_OUT      = 18'h20000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o.op    = OP_NOP;
    req_ready_o = 1'b0;
    rsp_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat_i.kind)
          KIND_WRITE: begin
            cmd_o.op = stat_i.idx_oor ? OP_ERR_IDX : OP_WR_IDX;
            state_d  = S_OUT;
          end
          KIND_APPEND: begin
            cmd_o.op = stat_i.full ? OP_ERR_FULL : OP_APPEND;
            state_d  = S_OUT;
          end
          KIND_SORT: begin
            if (stat_i.cnt_lt2) begin
              state_d = S_OUT;
            end else begin
              cmd_o.op = OP_SK_INIT;
              state_d  = S_SK_RD;
            end
          end
          KIND_LOOKUP: begin
            cmd_o.op = OP_LK_START;
            state_d  = stat_i.cnt_zero ? S_OUT : S_LK_CMP;
          end
          KIND_INTERP: begin
            cmd_o.op = OP_READ0;
            state_d  = stat_i.cnt_zero ? S_OUT : S_IN_FIRST;
          end
          default: state_d = S_OUT;
        endcase
      end
      S_SK_RD: begin
        cmd_o.op = OP_SK_READ;
        state_d  = S_SK_KEY;
      end
      S_SK_KEY: begin
        cmd_o.op = OP_SK_KEY;
        state_d  = S_SK_CMP;
      end
      S_SK_CMP: begin
        // shift the larger neighbor up until the key finds its slot
        if (stat_i.sk_gt) begin
          cmd_o.op = OP_SK_SHIFT;
          if (stat_i.j_one) state_d = S_SK_PUT;
        end else begin
          state_d = S_SK_PUT;
        end
      end
      S_SK_PUT: begin
        cmd_o.op = OP_SK_PUT;
        state_d  = stat_i.i_last ? S_DD_RD0 : S_SK_RD;
      end
      S_DD_RD0: begin
        cmd_o.op = OP_READ0;
        state_d  = S_DD_FIRST;
      end
      S_DD_FIRST: begin
        cmd_o.op = OP_DD_FIRST;
        state_d  = S_DD_CMP;
      end
      S_DD_CMP: begin
        cmd_o.op = OP_DD_STEP;
        if (stat_i.i_last) state_d = S_DD_END;
      end
      S_DD_END: begin
        cmd_o.op = OP_DD_END;
        state_d  = S_OUT;
      end
      S_LK_CMP: begin
        if (stat_i.lk_hit) begin
          cmd_o.op = OP_LK_HIT;
          state_d  = S_OUT;
        end else if (stat_i.i_last) begin
          state_d = S_OUT;
        end else begin
          cmd_o.op = OP_LK_STEP;
        end
      end
      S_IN_FIRST: begin
        if (stat_i.cnt_one) begin
          cmd_o.op = OP_IN_ONE;
          state_d  = S_OUT;
        end else begin
          cmd_o.op = OP_IN_FIRST;
          state_d  = S_IN_SCAN;
        end
      end
      S_IN_SCAN: begin
        if (stat_i.in_stop) begin
          cmd_o.op = OP_IN_SEG;
          state_d  = S_IN_CHK;
        end else begin
          cmd_o.op = OP_IN_STEP;
        end
      end
      S_IN_CHK: begin
        if (stat_i.in_flat) begin
          cmd_o.op = OP_IN_FLAT;
          state_d  = S_OUT;
        end else begin
          cmd_o.op = OP_IN_SETUP;
          state_d  = S_MUL;
        end
      end
      S_MUL: begin
        if (stat_i.mul_done) begin
          cmd_o.op = OP_DIV_INIT;
          state_d  = S_DIV;
        end else begin
          cmd_o.op = OP_MUL;
        end
      end
      S_DIV: begin
        cmd_o.op = OP_DIV;
        if (stat_i.div_done) state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.op = OP_FIN;
        state_d  = S_OUT;
      end
      S_OUT: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // the datapath only starts a request from idle and only computes outside S_OUT
  a_latch_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_LATCH) |-> (state_q == S_IDLE))
    else $error("request latched outside idle");
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_ready_i) |=> rsp_valid_o)
    else $error("result dropped before it was taken");
  a_no_op_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (cmd_o.op == OP_NOP))
    else $error("datapath command while a result waits");

endmodule

@@ design/cti_dp.sv @@
// Datapath: table memory, valid flags, scan indexes, shift-add multiplier,
// restoring divider and result registers. Depends on cti_pkg.
module cti_dp import cti_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [EIDX_W-1:0] entry_index_i,
  input  logic [VQ_W-1:0]   voltage_q8_i,
  input  logic [VAL_W-1:0]  entry_value_i,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  output logic [VAL_W-1:0]  result_value_o,
  output logic              found_o,
  output logic [STAT_W-1:0] status_o,
  output logic [CNT_W-1:0]  entry_count_o
);

  // table storage; an entry never written reads as zero through ok_q
  logic [VOLT_W-1:0] mem_v [TABLE_DEPTH];
  logic [VAL_W-1:0]  mem_f [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] ok_q;
  logic [VOLT_W-1:0] rdv_q;
  logic [VAL_W-1:0]  rdf_q;
  logic              rdok_q;

  logic [KIND_W-1:0]        kind_q;
  logic [EIDX_W-1:0]        eidx_q;
  logic signed [VQ_W-1:0]   q_q;
  logic signed [VOLT_W-1:0] vr_q;
  logic [VAL_W-1:0]         val_q;
  logic [CNT_W-1:0]         count_q;
  logic [VAL_W-1:0]         res_q;
  logic                     found_q;
  status_e                  status_q;

  logic [IDX_W-1:0] i_q, j_q, w_q;
  logic signed [VOLT_W-1:0] key_v_q, lastv_q, av_q, bv_q;
  logic [VAL_W-1:0]         key_f_q, af_q, bf_q;

  logic [PROD_W-1:0] ma_q, prod_q;
  logic [MB_W-1:0]   mb_q;
  logic [DEN_W-1:0]  den_q, rem_q;
  logic              neg_q;
  logic [DIV_W-1:0]  num_q;
  logic [DCNT_W-1:0] dcnt_q;

  logic signed [VOLT_W-1:0] rv;
  logic [VAL_W-1:0]         rf;
  logic [IDX_W-1:0]         raddr, waddr;
  logic                     we;
  logic [VOLT_W-1:0]        wv;
  logic [VAL_W-1:0]         wf;

  logic signed [VQ_W:0]     t_round;
  logic [VOLT_W-1:0]        vr_in;
  logic [EIDX_W:0]          idx_p1, wmax;
  logic [CNT_W-1:0]         wcnt;
  logic signed [VQ_W:0]     qx, av256, rv256, nb, nb_mag;
  logic signed [VAL_W:0]    na, na_mag;
  logic signed [VOLT_W:0]   dv, dv_mag;
  logic [DEN_W:0]           trial, trial_sub;
  logic                     ge;
  logic [SUM_W-1:0]         quot, sq, sum;
  logic [VAL_W-1:0]         sat;

  assign rv = rdok_q ? rdv_q : '0;
  assign rf = rdok_q ? rdf_q : '0;

  // round half up to whole volts; only the top end can overflow
  assign t_round = $signed({voltage_q8_i[VQ_W-1], voltage_q8_i}) + (VQ_W+1)'(128);
  assign vr_in   = (t_round[VQ_W:VQ_W-1] == 2'b01) ? {1'b0, {(VOLT_W-1){1'b1}}}
                                                   : t_round[VQ_W-1:8];

  assign idx_p1 = {1'b0, eidx_q} + (EIDX_W+1)'(1);
  assign wmax   = (idx_p1 > (EIDX_W+1)'(count_q)) ? idx_p1 : (EIDX_W+1)'(count_q);
  assign wcnt   = (wmax > (EIDX_W+1)'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : CNT_W'(wmax);

  assign qx    = {q_q[VQ_W-1], q_q};
  assign av256 = {av_q[VOLT_W-1], av_q, 8'h00};
  assign rv256 = {rv[VOLT_W-1], rv, 8'h00};

  assign na     = $signed({bf_q[VAL_W-1], bf_q}) - $signed({af_q[VAL_W-1], af_q});
  assign na_mag = na[VAL_W] ? -na : na;
  assign nb     = qx - av256;
  assign nb_mag = nb[VQ_W] ? -nb : nb;
  assign dv     = $signed({bv_q[VOLT_W-1], bv_q}) - $signed({av_q[VOLT_W-1], av_q});
  assign dv_mag = dv[VOLT_W] ? -dv : dv;

  assign trial     = {rem_q, num_q[DIV_W-1]};
  assign ge        = trial >= {1'b0, den_q};
  assign trial_sub = trial - {1'b0, den_q};

  assign quot = {2'b00, num_q};
  assign sq   = neg_q ? (~quot + SUM_W'(1)) : quot;
  assign sum  = {{(SUM_W-VAL_W){af_q[VAL_W-1]}}, af_q} + sq;
  always_comb begin
    if (!sum[SUM_W-1] && (sum[SUM_W-2:VAL_W-1] != '0)) begin
      sat = {1'b0, {(VAL_W-1){1'b1}}};
    end else if (sum[SUM_W-1] && (sum[SUM_W-2:VAL_W-1] != '1)) begin
      sat = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sat = sum[VAL_W-1:0];
    end
  end

  // memory port selection
  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = '0;
    wv    = vr_q;
    wf    = val_q;
    unique case (cmd_i.op)
      OP_WR_IDX: begin
        we    = 1'b1;
        waddr = eidx_q[IDX_W-1:0];
      end
      OP_APPEND: begin
        we    = 1'b1;
        waddr = IDX_W'(count_q);
      end
      OP_SK_READ: raddr = i_q;
      OP_SK_KEY:  raddr = j_q - IDX_W'(1);
      OP_SK_SHIFT: begin
        we    = 1'b1;
        waddr = j_q;
        wv    = rv;
        wf    = rf;
        raddr = j_q - IDX_W'(2);
      end
      OP_SK_PUT: begin
        we    = 1'b1;
        waddr = j_q;
        wv    = key_v_q;
        wf    = key_f_q;
      end
      OP_DD_FIRST: raddr = IDX_W'(1);
      OP_DD_STEP: begin
        raddr = i_q + IDX_W'(1);
        if (rv != lastv_q) begin
          we    = 1'b1;
          waddr = w_q;
          wv    = rv;
          wf    = rf;
        end
      end
      OP_LK_STEP:  raddr = i_q + IDX_W'(1);
      OP_IN_FIRST: raddr = IDX_W'(1);
      OP_IN_STEP:  raddr = i_q + IDX_W'(1);
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_v[waddr] <= wv;
      mem_f[waddr] <= wf;
    end
    rdv_q <= mem_v[raddr];
    rdf_q <= mem_f[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q    <= '0;
      rdok_q  <= 1'b0;
      count_q <= '0;
    end else begin
      rdok_q <= ok_q[raddr];
      if (we) ok_q[waddr] <= 1'b1;
      case (cmd_i.op)
        OP_WR_IDX: count_q <= wcnt;
        OP_APPEND: count_q <= count_q + CNT_W'(1);
        OP_DD_END: count_q <= CNT_W'(w_q);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LATCH: begin
        kind_q   <= kind_i;
        eidx_q   <= entry_index_i;
        q_q      <= voltage_q8_i;
        vr_q     <= vr_in;
        val_q    <= entry_value_i;
        res_q    <= '0;
        found_q  <= 1'b0;
        status_q <= ST_OK;
      end
      OP_ERR_IDX:  status_q <= ST_RANGE;
      OP_ERR_FULL: status_q <= ST_FULL;
      OP_SK_INIT:  i_q <= IDX_W'(1);
      OP_SK_READ:  j_q <= i_q;
      OP_SK_KEY: begin
        key_v_q <= rv;
        key_f_q <= rf;
      end
      OP_SK_SHIFT: j_q <= j_q - IDX_W'(1);
      OP_SK_PUT:   i_q <= i_q + IDX_W'(1);
      OP_DD_FIRST: begin
        lastv_q <= rv;
        i_q     <= IDX_W'(1);
        w_q     <= IDX_W'(1);
      end
      OP_DD_STEP: begin
        i_q <= i_q + IDX_W'(1);
        if (rv != lastv_q) begin
          lastv_q <= rv;
          w_q     <= w_q + IDX_W'(1);
        end
      end
      OP_LK_START: begin
        i_q      <= '0;
        status_q <= ST_NOT_FOUND;
      end
      OP_LK_STEP: i_q <= i_q + IDX_W'(1);
      OP_LK_HIT: begin
        res_q    <= rf;
        found_q  <= 1'b1;
        status_q <= ST_OK;
      end
      OP_IN_FIRST: begin
        av_q <= rv;
        af_q <= rf;
        i_q  <= IDX_W'(1);
      end
      OP_IN_ONE: res_q <= rf;
      OP_IN_STEP: begin
        av_q <= rv;
        af_q <= rf;
        i_q  <= i_q + IDX_W'(1);
      end
      OP_IN_SEG: begin
        bv_q <= rv;
        bf_q <= rf;
      end
      OP_IN_FLAT: res_q <= af_q;
      OP_IN_SETUP: begin
        ma_q   <= PROD_W'(na_mag[MA_W-1:0]);
        mb_q   <= nb_mag[MB_W-1:0];
        den_q  <= {dv_mag[VOLT_W-1:0], 8'h00};
        neg_q  <= (na[VAL_W] ^ nb[VQ_W]) ^ dv[VOLT_W];
        prod_q <= '0;
      end
      OP_MUL: begin
        if (mb_q[0]) prod_q <= prod_q + ma_q;
        ma_q <= ma_q << 1;
        mb_q <= mb_q >> 1;
      end
      OP_DIV_INIT: begin
        // add half the divisor for round to nearest
        num_q  <= {1'b0, prod_q} + DIV_W'(den_q >> 1);
        rem_q  <= '0;
        dcnt_q <= '0;
      end
      OP_DIV: begin
        rem_q  <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
        num_q  <= {num_q[DIV_W-2:0], ge};
        dcnt_q <= dcnt_q + DCNT_W'(1);
      end
      OP_FIN: res_q <= sat;
      default: res_q <= res_q;
    endcase
  end

  always_comb begin
    stat_o.kind     = kind_q;
    stat_o.idx_oor  = int'(eidx_q) >= TABLE_DEPTH;
    stat_o.full     = int'(count_q) >= MAX_ENTRIES;
    stat_o.cnt_zero = count_q == '0;
    stat_o.cnt_one  = count_q == CNT_W'(1);
    stat_o.cnt_lt2  = count_q < CNT_W'(2);
    stat_o.i_last   = i_q == IDX_W'(count_q - CNT_W'(1));
    stat_o.j_one    = j_q == IDX_W'(1);
    stat_o.sk_gt    = rv > key_v_q;
    stat_o.lk_hit   = rv == vr_q;
    stat_o.in_stop  = ((i_q == IDX_W'(1)) && (qx < av256)) ||
                      ((av256 <= qx) && (qx <= rv256)) || stat_o.i_last;
    stat_o.in_flat  = av_q == bv_q;
    stat_o.mul_done = mb_q == '0;
    stat_o.div_done = dcnt_q == DCNT_W'(DIV_W - 1);
  end

  assign result_value_o = res_q;
  assign found_o        = found_q;
  assign status_o       = status_q;
  assign entry_count_o  = count_q;

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_APPEND) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("append did not grow the count by one");
  a_dedupe_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_DD_END) |=> (count_q <= $past(count_q)))
    else $error("dedupe grew the table");
  a_dedupe_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_DD_STEP) |-> (w_q <= i_q))
    else $error("dedupe write ran ahead of its read");
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_LK_HIT) |=> (found_q && (status_q == ST_OK)))
    else $error("lookup hit without ok status");

endmodule

@@ design/calibration_table_interpolator_core.sv @@
// Calibration table interpolator: one request in, one result out, one at a time.
// Write, append and unused kinds go from the execute state straight to the result.
// Exact lookup: one table entry read per cycle over N entries, until the first match.
// Interpolate: segment scan, shift-add multiply, divide with rounding, saturate, output.
// Sort: insertion sort, then a dedupe pass. Reset clears count and valid flags at once.
// The next request can be taken in the cycle after the result is taken.
module calibration_table_interpolator_core import cti_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  cti_req_if.sink   req_i,
  cti_rsp_if.source rsp_o
);

  cmd_t  cmd;
  stat_t stat;
  logic  req_ready;
  logic  rsp_valid;

  cti_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cti_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .kind_i         (req_i.kind),
    .entry_index_i  (req_i.entry_index),
    .voltage_q8_i   (req_i.voltage_q8),
    .entry_value_i  (req_i.entry_value),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_value_o (rsp_o.result_value),
    .found_o        (rsp_o.found),
    .status_o       (rsp_o.status),
    .entry_count_o  (rsp_o.entry_count)
  );

  assign req_i.ready = req_ready;
  assign rsp_o.valid = rsp_valid;

endmodule

@@ test/calibration_table_interpolator_core_tb.sv @@
// Testbench for calibration_table_interpolator_core: random and directed table requests.
// Predicts every result from a behavioral copy of the table and checks it field by field.
// Depends on cti_pkg, cti_req_if and cti_rsp_if.
`timescale 1ns / 1ps
module calibration_table_interpolator_core_tb;
  import cti_pkg::*;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [EIDX_W-1:0] idx;
    logic [VQ_W-1:0]   volt;
    logic [VAL_W-1:0]  val;
  } request_t;

  typedef struct {
    logic [VAL_W-1:0]  val;
    logic              found;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count;
  } outcome_t;

  localparam longint CYCLE_LIMIT = 4000000;

  logic clk_i;
  logic rst_ni;
  cti_req_if req_if ();
  cti_rsp_if rsp_if ();

  calibration_table_interpolator_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  request_t pending_q[$];
  outcome_t outcome_q[$];
  request_t cur_req;
  int       errors;
  longint   cycles;
  bit       req_taken;
  bit       calm;
  int       send_gap;
  int       recv_gap;
  int       long_hold;
  bit       long_hold_go;

  // shadow of the calibration table
  int cal_volts[TABLE_DEPTH];
  int cal_vals[TABLE_DEPTH];
  int cal_count;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  function automatic int round_volt(logic signed [VQ_W-1:0] v);
    longint t;
    t = (longint'(v) + 128) >>> 8;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return int'(t);
  endfunction

  function automatic int saturate32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  function automatic int interp_value(longint q);
    int     i;
    longint v0, v1, na, nb, quo;
    longint unsigned ma, mb, den, mag;
    bit     neg;
    if (cal_count == 0) return 0;
    if (cal_count == 1) return cal_vals[0];
    if (q < longint'(cal_volts[0]) * 256) begin
      i = 0;
    end else begin
      for (i = 0; i + 1 < cal_count; i++)
        if (longint'(cal_volts[i]) * 256 <= q && longint'(cal_volts[i+1]) * 256 >= q) break;
      if (i + 1 >= cal_count) i = cal_count - 2;
    end
    v0 = cal_volts[i];
    v1 = cal_volts[i+1];
    if (v0 == v1) return cal_vals[i];
    na = longint'(cal_vals[i+1]) - longint'(cal_vals[i]);
    nb = q - v0 * 256;
    ma = (na < 0) ? -na : na;
    mb = (nb < 0) ? -nb : nb;
    den = ((v1 > v0) ? (v1 - v0) : (v0 - v1)) * 256;
    neg = ((na < 0) != (nb < 0)) != (v1 < v0);
    mag = (ma * mb + den / 2) / den;
    quo = neg ? -longint'(mag) : longint'(mag);
    return saturate32(longint'(cal_vals[i]) + quo);
  endfunction

  function automatic void sort_dedupe_table();
    int i, j, w, kv, kf;
    for (i = 1; i < cal_count; i++) begin
      kv = cal_volts[i];
      kf = cal_vals[i];
      j = i;
      while (j > 0 && cal_volts[j-1] > kv) begin
        cal_volts[j] = cal_volts[j-1];
        cal_vals[j] = cal_vals[j-1];
        j--;
      end
      cal_volts[j] = kv;
      cal_vals[j] = kf;
    end
    if (cal_count == 0) return;
    w = 1;
    for (i = 1; i < cal_count; i++)
      if (cal_volts[i] != cal_volts[w-1]) begin
        cal_volts[w] = cal_volts[i];
        cal_vals[w] = cal_vals[i];
        w++;
      end
    cal_count = w;
  endfunction

  function automatic outcome_t apply_request(request_t r);
    outcome_t o;
    int key, k;
    o.val = '0;
    o.found = 1'b0;
    o.status = ST_OK;
    case (r.kind)
      KIND_WRITE: begin
        if (r.idx >= TABLE_DEPTH) begin
          o.status = ST_RANGE;
        end else begin
          cal_volts[r.idx] = round_volt(r.volt);
          cal_vals[r.idx] = r.val;
          if (r.idx + 1 > cal_count) cal_count = r.idx + 1;
          if (cal_count > MAX_ENTRIES) cal_count = MAX_ENTRIES;
        end
      end
      KIND_APPEND: begin
        if (cal_count >= MAX_ENTRIES) begin
          o.status = ST_FULL;
        end else begin
          cal_volts[cal_count] = round_volt(r.volt);
          cal_vals[cal_count] = r.val;
          cal_count++;
        end
      end
      KIND_SORT: sort_dedupe_table();
      KIND_LOOKUP: begin
        key = round_volt(r.volt);
        o.status = ST_NOT_FOUND;
        for (k = 0; k < cal_count; k++)
          if (cal_volts[k] == key) begin
            o.val = cal_vals[k];
            o.found = 1'b1;
            o.status = ST_OK;
            break;
          end
      end
      KIND_INTERP: o.val = interp_value(longint'($signed(r.volt)));
      default: ;
    endcase
    o.count = CNT_W'(cal_count);
    return o;
  endfunction

  function automatic logic [VQ_W-1:0] pick_volt();
    if ($urandom_range(0, 9) < 7)
      return VQ_W'(($urandom_range(0, 40) - 20) * 256 + $urandom_range(0, 255));
    return VQ_W'($urandom);
  endfunction

  function automatic request_t make_req(logic [KIND_W-1:0] kind);
    request_t r;
    int sel;
    r.kind = kind;
    r.idx = EIDX_W'($urandom);
    r.volt = pick_volt();
    r.val = $urandom;
    if (kind == KIND_WRITE) begin
      sel = $urandom_range(0, 19);
      if (sel < 16) r.idx = EIDX_W'($urandom_range(0, 40));
      else if (sel < 18) r.idx = EIDX_W'($urandom_range(250, 255));
      else r.idx = EIDX_W'($urandom_range(256, 511));
    end
    return r;
  endfunction

  task automatic push(logic [KIND_W-1:0] kind, int idx, logic [VQ_W-1:0] v,
                      logic [VAL_W-1:0] val);
    request_t r;
    r.kind = kind;
    r.idx = EIDX_W'(idx);
    r.volt = v;
    r.val = val;
    pending_q.push_back(r);
  endtask

  // sender: hold a request until it is taken, then advance
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && !req_taken) begin
        // hold
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        req_if.valid <= 1'b0;
      end else if (pending_q.size() == 0) begin
        req_if.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        send_gap <= $urandom_range(0, 7);
        req_if.valid <= 1'b0;
      end else begin
        cur_req = pending_q.pop_front();
        req_if.valid <= 1'b1;
        req_if.kind <= cur_req.kind;
        req_if.entry_index <= cur_req.idx;
        req_if.voltage_q8 <= cur_req.volt;
        req_if.entry_value <= cur_req.val;
      end
      req_taken = 1'b0;
    end
  end

  // long receiver hold-off, counted in its own process
  always @(posedge clk_i) begin
    if (long_hold_go && long_hold == 0) long_hold <= 600;
    else if (long_hold > 1) long_hold <= long_hold - 1;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (long_hold > 1) begin
        rsp_if.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        rsp_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        recv_gap <= $urandom_range(0, 7);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // monitor: predict on each taken request, check each taken result
  always @(posedge clk_i) begin
    outcome_t want;
    request_t r;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at cycle %0d", cycles);
      $display("status: fail");
      $finish;
    end
    if (rst_ni && req_if.valid && req_if.ready) begin
      r.kind = req_if.kind;
      r.idx = req_if.entry_index;
      r.volt = req_if.voltage_q8;
      r.val = req_if.entry_value;
      outcome_q.push_back(apply_request(r));
      req_taken = 1'b1;
    end
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (outcome_q.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        want = outcome_q.pop_front();
        if (rsp_if.result_value !== want.val)
          report("result_value", $signed(rsp_if.result_value), $signed(want.val));
        if (rsp_if.found !== want.found) report("found", rsp_if.found, want.found);
        if (rsp_if.status !== want.status) report("status", rsp_if.status, want.status);
        if (rsp_if.entry_count !== want.count)
          report("entry_count", rsp_if.entry_count, want.count);
      end
    end
  end

  initial begin
    int sel, n;
    errors = 0;
    cycles = 0;
    req_taken = 1'b0;
    calm = 1'b0;
    send_gap = 0;
    recv_gap = 0;
    long_hold = 0;
    long_hold_go = 1'b0;
    cal_count = 0;
    foreach (cal_volts[i]) begin
      cal_volts[i] = 0;
      cal_vals[i] = 0;
    end
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.kind = KIND_WRITE;
    req_if.entry_index = '0;
    req_if.voltage_q8 = '0;
    req_if.entry_value = '0;
    rsp_if.ready = 1'b0;

    // empty table, then a small table with edge cases
    push(KIND_INTERP, 0, 24'h000100, 0);
    push(KIND_LOOKUP, 0, 24'h000000, 0);
    push(KIND_SORT, 0, 0, 0);
    push(KIND_APPEND, 0, 24'h000280, 32'h0001_0000);
    push(KIND_INTERP, 511, 24'h7fffff, 0);
    push(KIND_APPEND, 0, 24'h00057f, 32'h7fff_ffff);
    push(KIND_APPEND, 0, 24'h000a00, 32'h8000_0000);
    push(KIND_APPEND, 0, 24'h000a00, 32'h0000_1234);
    push(KIND_INTERP, 0, 24'h800000, 0);
    push(KIND_INTERP, 0, 24'h7fffff, 0);
    push(KIND_INTERP, 0, 24'h000480, 0);
    push(KIND_INTERP, 0, 24'h000a00, 0);
    push(KIND_LOOKUP, 0, 24'h00057f, 0);
    push(KIND_LOOKUP, 0, 24'h000580, 0);
    push(KIND_WRITE, 256, 24'h000100, 1);
    push(KIND_WRITE, 511, 24'h7fffff, 32'hffff_ffff);
    push(3'd5, 0, 0, 0);
    push(3'd6, 511, 24'hffffff, 32'hffff_ffff);
    push(3'd7, 0, 0, 0);
    push(KIND_WRITE, 1, 24'h7fffff, 32'h8000_0000);
    push(KIND_WRITE, 2, 24'h800000, 32'h7fff_ffff);
    push(KIND_WRITE, 255, 24'hfffe80, 32'h0000_0005);
    push(KIND_APPEND, 0, 24'h000100, 1);
    push(KIND_SORT, 0, 0, 0);
    push(KIND_INTERP, 0, 24'h000000, 0);

    for (n = 0; n < 600; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 22) pending_q.push_back(make_req(KIND_APPEND));
      else if (sel < 36) pending_q.push_back(make_req(KIND_WRITE));
      else if (sel < 62) pending_q.push_back(make_req(KIND_LOOKUP));
      else if (sel < 95) pending_q.push_back(make_req(KIND_INTERP));
      else if (sel < 98) pending_q.push_back(make_req(KIND_SORT));
      else pending_q.push_back(make_req(KIND_WRITE + 3'($urandom_range(5, 7))));
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_q.size() >= 450) @(posedge clk_i);
    @(posedge clk_i);
    long_hold_go <= 1'b1;
    @(posedge clk_i);
    long_hold_go <= 1'b0;

    while (pending_q.size() >= 60) @(posedge clk_i);
    calm = 1'b1;
    while (pending_q.size() != 0 || req_if.valid || outcome_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    if (errors == 0 && outcome_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ calibration_table_interpolator_core.f @@
design/cti_pkg.sv
design/cti_if.sv
design/cti_ctrl.sv
design/cti_dp.sv
design/calibration_table_interpolator_core.sv
test/calibration_table_interpolator_core_tb.sv
